### rtl/uis_pkg.sv
// ----------------------------------------------------------------------------
// uis_pkg
// Shared widths, status codes and defaults for the unique item stack.
// ----------------------------------------------------------------------------
package uis_pkg;

  localparam int CNT_W     = 5;
  localparam int ITEM_W    = 6;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

endpackage

### rtl/unique_item_stack.sv
// ----------------------------------------------------------------------------
// unique_item_stack
// Bounded stack of suit and rank items that refuses duplicate pushes.
// ----------------------------------------------------------------------------
// A pop, or a push while the stack is full, is answered from the execute state and
// out_tvalid is registered from it; a push that goes on to the search reads the
// store one entry at a time and stops at the first duplicate that it finds.
// Throughput: one word at a time; the next word is accepted the cycle after the
// current one finishes, even while its result still waits in the output register.
// Reset clears the entry count, the control state and sets capacity to 16.
module unique_item_stack #(
  parameter int DEPTH = uis_pkg::DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [uis_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // suit [1:0], rank [5:2], zeros
  input  logic                    in_tuser,   // mode
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata   // status [1:0], count [6:2], zero
);
  import uis_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (AW > CNT_W) ? AW : CNT_W;
  localparam int DW = $clog2(DEPTH + 1);
  localparam int LW = (DW > CNT_W) ? DW : CNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cap_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic                mode_r;
  logic [ITEM_W-1:0]   item_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [CNT_W-1:0]    out_count_r;
  logic                emit;
  logic                out_free;
  logic                full;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  logic [XW-1:0]       idx_ext, cnt_ext;
  logic [ITEM_W-1:0]   rdata_r;
  logic [ITEM_W-1:0]   mem [DEPTH];

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r};
  assign out_free   = !out_valid_r || out_tready;

  assign idx_ext = XW'(idx_r);
  assign cnt_ext = XW'(count_r);
  assign full    = (LW'(count_r) >= LW'(cap_r)) || (LW'(count_r) >= LW'(DEPTH));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    status_nxt = ST_OK;
    emit       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = idx_ext[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_r == MODE_POP) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        end else if (full) begin
          if (out_free) begin
            emit       = 1'b1;
            status_nxt = ST_FULL;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pend_r && (rdata_r == item_r)) begin
          if (out_free) begin
            emit       = 1'b1;
            status_nxt = ST_DUP;
            state_nxt  = S_IDLE;
          end
        end else if (idx_r == count_r) begin
          pend_nxt = 1'b0;
          if (out_free) begin
            emit      = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = cnt_ext[AW-1:0];
            count_nxt = count_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_tuser;
      item_r <= {in_tdata[1:0], in_tdata[5:2]};
    end
    if (emit) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= item_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

endmodule

### rtl/uis_checker.sv
// ----------------------------------------------------------------------------
// uis_checker
// Port-level checks for the unique item stack, bound to the top level.
// ----------------------------------------------------------------------------
module uis_checker #(
  parameter int DEPTH = uis_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import uis_pkg::*;

  localparam int LW = $clog2(DEPTH + 1) + 1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (LW'(out_tdata[6:2]) <= LW'(DEPTH)))
    else $error("reported count exceeds stack depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_EMPTY) |-> (out_tdata[6:2] == '0))
    else $error("empty status with nonzero count");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind unique_item_stack uis_checker #(.DEPTH(DEPTH)) u_uis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

### tb/unique_item_stack_tb.sv
// ----------------------------------------------------------------------------
// unique_item_stack_tb
// Self-checking bench for the unique item stack. A queue-fed driver offers
// push and pop words in bursts. A receiver stalls on shifting patterns, with
// two long hold-offs that back the block up. A shadow stack predicts status
// and count for every accepted word. Each result is checked in order against
// that prediction, across several capacity settings including zero and
// values above the depth.
// ----------------------------------------------------------------------------
module unique_item_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uis_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 70;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic       mode;
    logic [1:0] suit;
    logic [3:0] rank;
  } word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data = '0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata    = '0;  // suit [1:0], rank [5:2], zeros
  logic                in_tuser    = 1'b0;  // mode
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [7:0]          out_tdata;  // status [1:0], count [6:2], zero

  word_t               pending_words[$];
  result_t             expected_results[$];
  logic [ITEM_W-1:0]   shadow_items[DEPTH_DEF];
  int                  shadow_count = 0;
  int                  shadow_cap   = int'(CAP_RESET);
  int                  fail_cnt     = 0;
  int                  idle_cycles  = 0;
  int                  gap_left     = 0;
  int                  burst_left   = 0;
  word_t               nxt;
  int                  rx_cycle     = 0;
  int                  rx_taken     = 0;
  int                  hold_left    = 0;
  rx_pattern_t         rx_pat       = RX_OPEN;
  result_t             got;
  result_t             want;

  unique_item_stack u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic result_t apply_word(input word_t w);
    result_t           r;
    logic [ITEM_W-1:0] key;
    int                limit;
    bit                seen;
    key   = {w.suit, w.rank};
    limit = (shadow_cap < DEPTH_DEF) ? shadow_cap : DEPTH_DEF;
    seen  = 1'b0;
    if (w.mode == MODE_PUSH) begin
      for (int i = 0; i < shadow_count; i++)
        if (shadow_items[i] == key) seen = 1'b1;
      if (shadow_count >= limit) begin
        r.status = ST_FULL;
      end else if (seen) begin
        r.status = ST_DUP;
      end else begin
        shadow_items[shadow_count] = key;
        shadow_count++;
        r.status = ST_OK;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      shadow_count--;
      r.status = ST_OK;
    end
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, nxt.rank, nxt.suit};
        in_tuser  <= nxt.mode;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (out_tvalid && out_tready) begin
      rx_taken = rx_taken + 1;
      if (rx_taken == 100 || rx_taken == 450) hold_left = HOLD_CYCLES;
    end
    if (rx_cycle % 64 == 0) rx_pat = rx_pattern_t'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_pat)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
        default:   out_tready <= ((rx_cycle % 8) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) shadow_cap = int'(cfg_wr_data);
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.count  = out_tdata[6:2];
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d", got.status, got.count);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_word(word_t'{in_tuser, in_tdata[1:0], in_tdata[5:2]}));
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int    cap_plan[NUM_PHASES];
    int    push_pct;
    word_t w;
    cap_plan = '{3, 0, 31, 16, 1, 0, 0, 0, 8, 17};
    for (int p = 5; p < 8; p++) cap_plan[p] = $urandom_range(0, 31);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_words.push_back(word_t'{MODE_POP, 2'd0, 4'd0});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd0, 4'd0});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd3, 4'd15});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd3, 4'd15});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd0, 4'd0});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd2, 4'd14});
    for (int r = 0; r < 13; r++)
      pending_words.push_back(word_t'{MODE_PUSH, 2'd1, 4'(r)});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd1, 4'd13});
    pending_words.push_back(word_t'{MODE_PUSH, 2'd0, 4'd0});
    pending_words.push_back(word_t'{MODE_POP, 2'd3, 4'd15});
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= CNT_W'(cap_plan[p]);
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      @(negedge clk);
      push_pct = $urandom_range(3, 9) * 10;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w.mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
        if ($urandom_range(0, 1) == 1) begin
          w.suit = 2'($urandom_range(0, 1));
          w.rank = 4'($urandom_range(0, 3));
        end else begin
          w.suit = 2'($urandom);
          w.rank = 4'($urandom);
        end
        pending_words.push_back(w);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
